/* hdl/plira_pkg.sv */
// ----------------------------------------------------------------------------
// plira_pkg
// Shared types and constants for the pair list with insert/remove at index.
// ----------------------------------------------------------------------------
package plira_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int KIND_BITS   = 3;
  localparam int FIELD_BITS  = 32;
  localparam int POS_BITS    = 4;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;
  localparam int CNT_BITS    = $clog2(DEPTH + 1);
  // width for comparing positions, indexes and the count against each other
  localparam int CMP_BITS    = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CMP_BITS-1:0]   cmp_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_APPEND    = 3'd0,
    KIND_INSERT    = 3'd1,
    KIND_REMOVE    = 3'd2,
    KIND_READ_POS  = 3'd3,
    KIND_READ_KEY  = 3'd4,
    KIND_WRITE_KEY = 3'd5
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NOKEY = 2'd3
  } status_t;

  typedef struct packed {
    key_t   key;
    value_t value;
  } entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   do_append;
    logic   do_insert;
    logic   do_remove;
    logic   do_read_pos;
    logic   do_lookup;
    logic   do_write_key;
    cmp_t   pos;
    cmp_t   count;
    entry_t data;
  } cmd_t;

endpackage

/* hdl/plira_if.sv */
// ----------------------------------------------------------------------------
// plira_in_if / plira_out_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface plira_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                kind;
  logic signed [31:0]        key;
  logic signed [31:0]        value;
  logic [3:0]                position;

  modport source (output valid, kind, key, value, position, input ready);
  modport sink   (input valid, kind, key, value, position, output ready);
  modport monitor (input valid, ready, kind, key, value, position);
endinterface

interface plira_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        key_out;
  logic signed [31:0]        value_out;
  logic [1:0]                status;
  logic [4:0]                count_out;

  modport source (output valid, key_out, value_out, status, count_out, input ready);
  modport sink   (input valid, key_out, value_out, status, count_out, output ready);
  modport monitor (input valid, ready, key_out, value_out, status, count_out);
endinterface

/* hdl/plira_cell.sv */
// ----------------------------------------------------------------------------
// plira_cell
// One list slot: holds a pair, shifts with its neighbors on insert/remove,
// takes part in the first-match search and the read-out chain.
// ----------------------------------------------------------------------------
module plira_cell
  import plira_pkg::*;
(
  input  logic   clk,
  input  cmp_t   idx,
  input  cmd_t   cmd,
  input  entry_t left,
  input  entry_t right,
  output entry_t entry,
  input  logic   seen_in,
  output logic   seen_out,
  input  entry_t rd_in,
  output entry_t rd_out
);

  entry_t entry_r, entry_nxt;
  logic   in_list, match, first, sel;
  cmp_t   idx_up;

  assign idx_up   = idx + cmp_t'(1);
  assign in_list  = idx < cmd.count;
  assign match    = cmd.do_lookup && in_list && (entry_r.key == cmd.data.key);
  assign first    = match && !seen_in;
  assign seen_out = seen_in || match;
  assign sel      = (cmd.do_read_pos && (idx == cmd.pos)) || first;
  assign rd_out   = sel ? entry_r : rd_in;
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.do_append && (idx == cmd.count)) begin
      entry_nxt = cmd.data;
    end
    if (cmd.do_insert) begin
      if (idx == cmd.pos) begin
        entry_nxt = cmd.data;
      end else if ((idx > cmd.pos) && (idx <= cmd.count)) begin
        entry_nxt = left;
      end
    end
    if (cmd.do_remove && (idx >= cmd.pos) && (idx_up < cmd.count)) begin
      entry_nxt = right;
    end
    if (cmd.do_write_key && first) begin
      entry_nxt.value = cmd.data.value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* hdl/pair_list_insert_remove_at_index.sv */
// ----------------------------------------------------------------------------
// pair_list_insert_remove_at_index
// Gap-free list of key/value pairs held in a row of shifting cells.
// ----------------------------------------------------------------------------
// One operation is taken per clock cycle unless an untaken result stalls it, and
// its result appears in the output register on the next cycle; a new request is
// taken in the same cycle the previous result transfers. The whole row of
// cells updates at once for insert, remove and key lookup alike; the key
// search and the read-out both ripple through the cells, setting the clock period.
// Stores need no clearing after reset: only entries below the count are read.
// ----------------------------------------------------------------------------
module pair_list_insert_remove_at_index
  import plira_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  plira_in_if.sink    in_ch,
  plira_out_if.source out_ch
);

  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                out_valid_r;
  entry_t              out_entry_r;
  status_t             status_r, status_nxt;

  logic   accept, full, pos_le, pos_lt;
  cmp_t   pos_c, count_c;
  kind_t  kind;
  cmd_t   cmd;
  entry_t new_entry;

  entry_t cell_entry [DEPTH];
  entry_t cell_left  [DEPTH];
  entry_t cell_right [DEPTH];
  logic   seen       [DEPTH+1];
  entry_t rd         [DEPTH+1];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign kind      = kind_t'(in_ch.kind);
  assign pos_c     = cmp_t'(in_ch.position);
  assign count_c   = cmp_t'(count_r);
  assign full      = count_c >= cmp_t'(DEPTH);
  assign pos_le    = pos_c <= count_c;
  assign pos_lt    = pos_c < count_c;
  assign new_entry.key   = key_t'($unsigned(in_ch.key));
  assign new_entry.value = value_t'($unsigned(in_ch.value));

  always_comb begin
    cmd              = '0;
    cmd.pos          = pos_c;
    cmd.count        = count_c;
    cmd.data         = new_entry;
    cmd.do_append    = accept && (kind == KIND_APPEND) && !full;
    cmd.do_insert    = accept && (kind == KIND_INSERT) && !full && pos_le;
    cmd.do_remove    = accept && (kind == KIND_REMOVE) && pos_lt;
    cmd.do_read_pos  = ((kind == KIND_REMOVE) || (kind == KIND_READ_POS)) && pos_lt;
    cmd.do_lookup    = (kind == KIND_READ_KEY) || (kind == KIND_WRITE_KEY);
    cmd.do_write_key = accept && (kind == KIND_WRITE_KEY);
  end

  assign seen[0] = 1'b0;
  assign rd[0]   = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    // end cells never shift in from outside; tie to their own contents
    if (g == 0) begin : g_first
      assign cell_left[g] = cell_entry[g];
    end else begin : g_mid_l
      assign cell_left[g] = cell_entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign cell_right[g] = cell_entry[g];
    end else begin : g_mid_r
      assign cell_right[g] = cell_entry[g+1];
    end

    plira_cell u_cell (
      .clk      (clk),
      .idx      (cmp_t'(g)),
      .cmd      (cmd),
      .left     (cell_left[g]),
      .right    (cell_right[g]),
      .entry    (cell_entry[g]),
      .seen_in  (seen[g]),
      .seen_out (seen[g+1]),
      .rd_in    (rd[g]),
      .rd_out   (rd[g+1])
    );
  end

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    case (kind)
      KIND_APPEND: begin
        if (full) status_nxt = ST_FULL;
        else count_nxt = count_r + CNT_BITS'(1);
      end
      KIND_INSERT: begin
        if (full) status_nxt = ST_FULL;
        else if (!pos_le) status_nxt = ST_RANGE;
        else count_nxt = count_r + CNT_BITS'(1);
      end
      KIND_REMOVE: begin
        if (!pos_lt) status_nxt = ST_RANGE;
        else count_nxt = count_r - CNT_BITS'(1);
      end
      KIND_READ_POS: begin
        if (!pos_lt) status_nxt = ST_RANGE;
      end
      KIND_READ_KEY, KIND_WRITE_KEY: begin
        if (!seen[DEPTH]) status_nxt = ST_NOKEY;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_entry_r <= rd[DEPTH];
      status_r    <= status_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_out   = FIELD_BITS'(out_entry_r.key);
  assign out_ch.value_out = FIELD_BITS'(out_entry_r.value);
  assign out_ch.status    = status_r;
  assign out_ch.count_out = COUNT_BITS'(count_r);

endmodule

/* hdl/plira_checker.sv */
// ----------------------------------------------------------------------------
// plira_checker
// Port-level checks on the pair list result channel.
// ----------------------------------------------------------------------------
module plira_checker
  import plira_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [FIELD_BITS-1:0]  key_out,
  input logic [FIELD_BITS-1:0]  value_out,
  input logic [STATUS_BITS-1:0] status,
  input logic [COUNT_BITS-1:0]  count_out
);

  // a held result stays put until it transfers
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(count_out))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_out <= COUNT_BITS'(DEPTH))
    else $error("count beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL) |-> count_out == COUNT_BITS'(DEPTH))
    else $error("full status with spare room");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (key_out == '0)
      && (value_out == '0))
    else $error("failed operation returned data");

endmodule

bind pair_list_insert_remove_at_index plira_checker u_plira_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .key_out   (out_ch.key_out),
  .value_out (out_ch.value_out),
  .status    (out_ch.status),
  .count_out (out_ch.count_out)
);

/* tb/tb_pair_list_insert_remove_at_index.sv */
// ----------------------------------------------------------------------------
// tb_pair_list_insert_remove_at_index
// Drives append, insert, remove, positional and key operations into the pair
// list through its request channel and checks every result on the result
// channel against a scoreboard fed by an in-bench list model or the plan. A short
// directed plan covers the empty, full and error cases first. A long random
// run follows that alternates between growing and draining the list, with
// random idling on both sides, two long result back-pressure stretches and a
// full drain pause.
// ----------------------------------------------------------------------------
module tb_pair_list_insert_remove_at_index;
  import plira_pkg::*;

  // kind codes with no operation behind them
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  localparam int RANDOM_OPS = 1080;
  localparam int CALM_LO    = 500;
  localparam int CALM_HI    = 700;
  localparam int HOLD_AT_A  = 300;
  localparam int HOLD_AT_B  = 900;
  localparam int HOLD_LEN   = 64;
  localparam int DRAIN_AT   = 850;

  typedef struct {
    logic [2:0] kind;
    key_t       key;
    value_t     value;
    logic [3:0] pos;
  } list_op_t;

  typedef struct {
    key_t       key;
    value_t     value;
    status_t    st;
    logic [4:0] cnt;
  } list_res_t;

  typedef struct {
    list_op_t  op;
    int        reps;
    bit        typed;
    list_res_t res;
  } plan_row_t;

  logic clk;
  logic rst_n;

  plira_in_if  in_ch();
  plira_out_if out_ch();

  pair_list_insert_remove_at_index uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // list model state
  key_t   list_keys [DEPTH];
  value_t list_vals [DEPTH];
  int     list_len;

  list_res_t due_results[$];
  plan_row_t plan[$];
  int        items_sent;
  int        results_seen = 0;
  int        mismatches = 0;
  int        hold_left = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic list_res_t apply_list_op(input list_op_t op);
    list_res_t r;
    int        hit;
    r.key   = '0;
    r.value = '0;
    r.st    = ST_OK;
    hit     = -1;
    case (op.kind)
      KIND_APPEND: begin
        if (list_len >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          list_keys[list_len] = op.key;
          list_vals[list_len] = op.value;
          list_len++;
        end
      end
      KIND_INSERT: begin
        // full check wins over the position check
        if (list_len >= DEPTH) begin
          r.st = ST_FULL;
        end else if (int'(op.pos) > list_len) begin
          r.st = ST_RANGE;
        end else begin
          for (int i = list_len; i > int'(op.pos); i--) begin
            list_keys[i] = list_keys[i-1];
            list_vals[i] = list_vals[i-1];
          end
          list_keys[op.pos] = op.key;
          list_vals[op.pos] = op.value;
          list_len++;
        end
      end
      KIND_REMOVE: begin
        if (int'(op.pos) >= list_len) begin
          r.st = ST_RANGE;
        end else begin
          r.key   = list_keys[op.pos];
          r.value = list_vals[op.pos];
          for (int i = int'(op.pos); i < list_len - 1; i++) begin
            list_keys[i] = list_keys[i+1];
            list_vals[i] = list_vals[i+1];
          end
          list_len--;
        end
      end
      KIND_READ_POS: begin
        if (int'(op.pos) >= list_len) begin
          r.st = ST_RANGE;
        end else begin
          r.key   = list_keys[op.pos];
          r.value = list_vals[op.pos];
        end
      end
      KIND_READ_KEY, KIND_WRITE_KEY: begin
        for (int i = 0; i < list_len; i++) begin
          if (hit < 0 && list_keys[i] == op.key) hit = i;
        end
        if (hit < 0) begin
          r.st = ST_NOKEY;
        end else begin
          r.key   = list_keys[hit];
          r.value = list_vals[hit];
          if (op.kind == KIND_WRITE_KEY) list_vals[hit] = op.value;
        end
      end
      default: ;
    endcase
    r.cnt = list_len[4:0];
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] kind, input key_t k, input value_t v,
                                  input logic [3:0] p, input int reps, input bit typed,
                                  input status_t st, input int cnt);
    plan_row_t row;
    row.op.kind   = kind;
    row.op.key    = k;
    row.op.value  = v;
    row.op.pos    = p;
    row.reps      = reps;
    row.typed     = typed;
    row.res.key   = '0;
    row.res.value = '0;
    row.res.st    = st;
    row.res.cnt   = cnt[4:0];
    plan.insert(plan.size(), row);
  endfunction

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 10) return key_t'($urandom);
    if (r < 45 && list_len > 0) return list_keys[$urandom_range(list_len - 1)];
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return key_t'($urandom_range(7));
    endcase
  endfunction

  // alternates between phases that fill the list and phases that drain it
  function automatic list_op_t make_random_op(input int idx);
    list_op_t op;
    bit       grow;
    int       r;
    grow     = ((idx / 80) % 2) == 0;
    r        = $urandom_range(99);
    op.key   = pick_key();
    op.value = value_t'($urandom);
    if ($urandom_range(4) == 0) op.pos = 4'($urandom_range(15));
    else op.pos = 4'($urandom_range((list_len > 15) ? 15 : list_len));
    if (r < 3) op.kind = $urandom_range(1) ? KIND_UNUSED_6 : KIND_UNUSED_7;
    else if (r < (grow ? 28 : 11)) op.kind = KIND_APPEND;
    else if (r < (grow ? 53 : 21)) op.kind = KIND_INSERT;
    else if (r < (grow ? 62 : 60)) op.kind = KIND_REMOVE;
    else if (r < 74) op.kind = KIND_READ_POS;
    else if (r < 87) op.kind = KIND_READ_KEY;
    else op.kind = KIND_WRITE_KEY;
    return op;
  endfunction

  function automatic bit sender_calm();
    return items_sent >= CALM_LO && items_sent < CALM_HI;
  endfunction

  task automatic issue(input list_op_t op, input bit typed, input list_res_t typed_res);
    list_res_t model_res;
    while (!sender_calm() && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= op.kind;
    in_ch.key      <= op.key;
    in_ch.value    <= op.value;
    in_ch.position <= op.pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model_res = apply_list_op(op);
    due_results.insert(due_results.size(), typed ? typed_res : model_res);
    items_sent++;
  endtask

  // result checker and result-side ready in one process
  always @(posedge clk) begin
    list_res_t want;
    bit        took;
    took = 1'b0;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      took = 1'b1;
      results_seen++;
      if (due_results.size() == 0) begin
        $error("unexpected result transfer: key_out %h status %0d",
               out_ch.key_out, out_ch.status);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_ch.key_out !== want.key) begin
          $error("key_out expected %h actual %h", want.key, out_ch.key_out);
          mismatches++;
        end
        if (out_ch.value_out !== want.value) begin
          $error("value_out expected %h actual %h", want.value, out_ch.value_out);
          mismatches++;
        end
        if (out_ch.status !== want.st) begin
          $error("status expected %0d actual %0d", want.st, out_ch.status);
          mismatches++;
        end
        if (out_ch.count_out !== want.cnt) begin
          $error("count_out expected %0d actual %0d", want.cnt, out_ch.count_out);
          mismatches++;
        end
      end
    end
    if (took && (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B))
      hold_left = HOLD_LEN;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 25);
    end
  end

  initial begin
    list_op_t  op;
    list_res_t none;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_APPEND;
    in_ch.key      = '0;
    in_ch.value    = '0;
    in_ch.position = '0;
    list_len       = 0;
    items_sent     = 0;
    none.key       = '0;
    none.value     = '0;
    none.st        = ST_OK;
    none.cnt       = '0;

    // empty list, error paths and extremes
    add_row(KIND_READ_POS,  32'h0,         32'h0,         4'd0,  1, 1, ST_RANGE, 0);
    add_row(KIND_REMOVE,    32'h0,         32'h0,         4'd0,  1, 1, ST_RANGE, 0);
    add_row(KIND_READ_KEY,  32'h0,         32'h0,         4'd0,  1, 1, ST_NOKEY, 0);
    add_row(KIND_WRITE_KEY, 32'h0,         32'h1234_5678, 4'd0,  1, 1, ST_NOKEY, 0);
    add_row(KIND_INSERT,    32'h1,         32'h1,         4'd1,  1, 1, ST_RANGE, 0);
    add_row(KIND_UNUSED_6,  32'hffff_ffff, 32'hffff_ffff, 4'd15, 1, 1, ST_OK,    0);
    add_row(KIND_UNUSED_7,  32'h8000_0000, 32'h7fff_ffff, 4'd15, 1, 1, ST_OK,    0);
    add_row(KIND_APPEND,    32'h8000_0000, 32'h7fff_ffff, 4'd9,  1, 1, ST_OK,    1);
    add_row(KIND_INSERT,    32'h7fff_ffff, 32'h8000_0000, 4'd0,  1, 1, ST_OK,    2);
    // position equal to the count behaves as append
    add_row(KIND_INSERT,    32'hffff_ffff, 32'h0,         4'd2,  1, 1, ST_OK,    3);
    add_row(KIND_INSERT,    32'h5,         32'h5,         4'd5,  1, 1, ST_RANGE, 3);
    add_row(KIND_READ_POS,  32'h0,         32'h0,         4'd0,  1, 0, ST_OK,    0);
    add_row(KIND_READ_KEY,  32'h8000_0000, 32'h0,         4'd0,  1, 0, ST_OK,    0);
    add_row(KIND_WRITE_KEY, 32'hffff_ffff, 32'hffff_ffff, 4'd0,  1, 0, ST_OK,    0);
    add_row(KIND_REMOVE,    32'h0,         32'h0,         4'd1,  1, 0, ST_OK,    0);
    add_row(KIND_READ_POS,  32'h0,         32'h0,         4'd15, 1, 1, ST_RANGE, 2);
    // fill to capacity; keys 3..16
    add_row(KIND_APPEND,    32'h3,         32'hcafe_0000, 4'd0,  14, 0, ST_OK,   0);
    add_row(KIND_APPEND,    32'h42,        32'h42,        4'd0,  1, 1, ST_FULL,  16);
    add_row(KIND_INSERT,    32'h42,        32'h42,        4'd0,  1, 1, ST_FULL,  16);
    add_row(KIND_READ_POS,  32'h0,         32'h0,         4'd15, 1, 0, ST_OK,    0);
    add_row(KIND_WRITE_KEY, 32'h10,        32'h0bad_f00d, 4'd0,  1, 0, ST_OK,    0);
    add_row(KIND_REMOVE,    32'h0,         32'h0,         4'd15, 1, 0, ST_OK,    0);
    add_row(KIND_INSERT,    32'h3,         32'h5a5a_a5a5, 4'd15, 1, 0, ST_OK,    0);
    add_row(KIND_READ_KEY,  32'h3,         32'h0,         4'd0,  1, 0, ST_OK,    0);
    add_row(KIND_REMOVE,    32'h0,         32'h0,         4'd0,  1, 0, ST_OK,    0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      for (int n = 0; n < plan[i].reps; n++) begin
        op     = plan[i].op;
        op.key = op.key + key_t'(n);
        issue(op, plan[i].typed, plan[i].res);
      end
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == DRAIN_AT) begin
        // let every outstanding result come back before going on
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
      end
      issue(make_random_op(n), 1'b0, none);
    end
    in_ch.valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
